>>> rtl/dfacc_pkg.sv
// Shared types, constants and character-class tests for the lexer DFA step block.
package dfacc_pkg;

   localparam int STATE_COUNT_DEF = 64;
   localparam int STATE_W         = 6;
   localparam int SYM_W           = 9;
   localparam int SIU_W           = 7;
   localparam int CLASS_KEYS      = 9;
   localparam int LIT_KEYS        = 256;
   localparam int CNT_W           = 11;

   localparam logic [SIU_W-1:0] SIU_RESET = 7'd64;
   localparam logic [SYM_W-1:0] KEY_LAST  = 9'd264;

   // request kinds carried in req_tuser
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   // class lanes, in lookup priority order
   localparam int CLS_LETTER  = 0;
   localparam int CLS_SPACE   = 1;
   localparam int CLS_DIGIT   = 2;
   localparam int CLS_NZDIGIT = 3;
   localparam int CLS_OCTAL   = 4;
   localparam int CLS_HEX     = 5;
   localparam int CLS_DQ_STR  = 6;
   localparam int CLS_SQ_STR  = 7;
   localparam int CLS_NO_BSL  = 8;

   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_EIGHT  = 8'h38;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_F   = 8'h66;
   localparam logic [7:0] CH_LO_Z   = 8'h7A;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_F   = 8'h46;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_BSL    = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef struct packed {
      logic               valid;
      logic [STATE_W-1:0] state;
   } entry_type;

   typedef struct packed {
      logic      en;
      entry_type data;
   } lit_wr_type;

   typedef struct packed {
      logic                  en;
      logic [CLASS_KEYS-1:0] mask;
      entry_type             data;
   } cls_wr_type;

   // item held between memory read and result register
   typedef struct packed {
      logic       step;
      logic       ok;
      logic [7:0] ch;
   } s1_type;

   typedef struct packed {
      logic               found;
      logic [STATE_W-1:0] next_state;
   } rsp_type;

   function automatic logic [CLASS_KEYS-1:0] class_hits(input logic [7:0] c);
      logic [CLASS_KEYS-1:0] h;
      logic                  dig;
      dig = (c >= CH_ZERO) && (c <= CH_NINE);
      h[CLS_LETTER]  = ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
      h[CLS_SPACE]   = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
      h[CLS_DIGIT]   = dig;
      h[CLS_NZDIGIT] = dig && (c != CH_ZERO);
      h[CLS_OCTAL]   = dig && (c != CH_EIGHT) && (c != CH_NINE);
      h[CLS_HEX]     = dig || ((c >= CH_LO_A) && (c <= CH_LO_F))
                           || ((c >= CH_UP_A) && (c <= CH_UP_F));
      h[CLS_DQ_STR]  = (c != CH_BSL) && (c != CH_DQUOTE) && (c != CH_NL);
      h[CLS_SQ_STR]  = (c != CH_BSL) && (c != CH_SQUOTE) && (c != CH_NL);
      h[CLS_NO_BSL]  = (c != CH_BSL);
      return h;
   endfunction

endpackage

>>> rtl/dfa_step_with_char_classes.sv
// Top level of the lexer DFA transition store and step unit.
// Takes one word per cycle, writes and steps alike, and presents one result word
// per request, in order, through the read stage and output register; rsp back-pressure
// stalls req only once that two-deep pipe (read stage plus output register) is full.
// The rate is set by the single port pair of each transition memory: a write
// lands at acceptance, a step reads the literal entry and the state's class row
// in the same cycle. After reset a clearing pass walks every literal memory address,
// clearing class rows alongside; req_tready stays low until it ends, csr writes
// are taken throughout.
module dfa_step_with_char_classes import dfacc_pkg::*; #(
   parameter int STATE_COUNT = STATE_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [SIU_W-1:0]  csr_wdata,    // states_in_use
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_tuser,    // func
   input  logic [23:0]       req_tdata,    // from_state, state_present, symbol, to_state, pad
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata     // next_state, found, pad
);

   localparam int SW       = $clog2(STATE_COUNT);
   localparam int AW       = SW + 8;
   localparam int LIT_LAST = STATE_COUNT * LIT_KEYS - 1;
   localparam logic [CNT_W-1:0] STATE_LIM = CNT_W'(STATE_COUNT);

   logic [SIU_W-1:0]   siu_ff;
   logic               clr_busy_ff, clr_busy_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;
   logic               s1_valid_ff, s1_valid_in;
   s1_type             s1_ff, s1_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, pick_rsp;

   logic [STATE_W-1:0] from_state, to_state;
   logic               state_present;
   logic [SYM_W-1:0]   symbol;
   logic [15:0]        from_ext;
   logic [SW-1:0]      from_idx;
   logic               acc, is_step, wr_ok, step_ok, rsp_free, s1_free;
   lit_wr_type         lit_wr;
   cls_wr_type         cls_wr;
   logic [AW-1:0]      lit_wr_addr, lit_rd_addr;
   logic [SW-1:0]      cls_wr_row;
   entry_type          lit_rd;
   entry_type [CLASS_KEYS-1:0] cls_rd;

   assign from_state    = req_tdata[5:0];
   assign state_present = req_tdata[6];
   assign symbol        = req_tdata[15:7];
   assign to_state      = req_tdata[21:16];
   assign from_ext      = 16'(from_state);
   assign from_idx      = from_ext[SW-1:0];

   assign is_step  = (req_tuser == FUNC_STEP);
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign s1_free  = !s1_valid_ff || rsp_free;
   assign req_tready = !clr_busy_ff && s1_free;
   assign acc      = req_tvalid && req_tready;

   assign wr_ok = ({1'b0, from_state} < siu_ff) && ({1'b0, to_state} < siu_ff)
                  && (CNT_W'(from_state) < STATE_LIM) && (CNT_W'(to_state) < STATE_LIM)
                  && (symbol <= KEY_LAST);
   assign step_ok = state_present && (CNT_W'(from_state) < STATE_LIM) && !symbol[8];

   assign lit_rd_addr = {from_idx, symbol[7:0]};

   // write ports: clearing pass owns them until done
   always_comb begin
      if (clr_busy_ff) begin
         lit_wr      = '{en: 1'b1, data: '0};
         lit_wr_addr = clr_addr_ff;
         cls_wr      = '{en: 1'b1, mask: '1, data: '0};
         cls_wr_row  = clr_addr_ff[AW-1:8];
      end else begin
         lit_wr.en    = acc && !is_step && wr_ok && !symbol[8];
         lit_wr.data  = '{valid: 1'b1, state: to_state};
         lit_wr_addr  = lit_rd_addr;
         cls_wr.en    = acc && !is_step && wr_ok && symbol[8];
         for (int l = 0; l < CLASS_KEYS; l++) begin
            cls_wr.mask[l] = (symbol[3:0] == 4'(l));
         end
         cls_wr.data  = '{valid: 1'b1, state: to_state};
         cls_wr_row   = from_idx;
      end
   end

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(LIT_LAST)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (s1_free) begin
         s1_valid_in = acc;
         s1_in.step  = is_step;
         s1_in.ok    = is_step ? step_ok : wr_ok;
         s1_in.ch    = symbol[7:0];
      end
      rsp_valid_in = rsp_free ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         siu_ff       <= SIU_RESET;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            siu_ff <= csr_wdata;
         end
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      if (rsp_free) begin
         rsp_ff <= pick_rsp;
      end
   end

   dfacc_lit_mem #(.STATE_COUNT(STATE_COUNT)) u_lit_mem (
      .clock      (clock),
      .wr         (lit_wr),
      .wr_addr    (lit_wr_addr),
      .rd_en      (acc && is_step && step_ok),
      .rd_addr    (lit_rd_addr),
      .rd_data_ff (lit_rd)
   );

   dfacc_cls_mem #(.STATE_COUNT(STATE_COUNT)) u_cls_mem (
      .clock      (clock),
      .wr         (cls_wr),
      .wr_row     (cls_wr_row),
      .rd_en      (acc && is_step && step_ok),
      .rd_row     (from_idx),
      .rd_data_ff (cls_rd)
   );

   dfacc_pick u_pick (
      .s1  (s1_ff),
      .lit (lit_rd),
      .cls (cls_rd),
      .rsp (pick_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.found, rsp_ff.next_state};

endmodule

>>> rtl/dfacc_lit_mem.sv
// Literal transition memory: one entry per (state, byte), one write and one read port.
module dfacc_lit_mem import dfacc_pkg::*; #(
   parameter int STATE_COUNT = STATE_COUNT_DEF
) (
   input  logic                                 clock,
   input  lit_wr_type                           wr,
   input  logic [$clog2(STATE_COUNT)+7:0]       wr_addr,
   input  logic                                 rd_en,
   input  logic [$clog2(STATE_COUNT)+7:0]       rd_addr,
   output entry_type                            rd_data_ff
);

   localparam int DEPTH = STATE_COUNT * LIT_KEYS;

   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/dfacc_cls_mem.sv
// Class transition memory: one row of nine class entries per state, lane-masked writes.
module dfacc_cls_mem import dfacc_pkg::*; #(
   parameter int STATE_COUNT = STATE_COUNT_DEF
) (
   input  logic                                  clock,
   input  cls_wr_type                            wr,
   input  logic [$clog2(STATE_COUNT)-1:0]        wr_row,
   input  logic                                  rd_en,
   input  logic [$clog2(STATE_COUNT)-1:0]        rd_row,
   output entry_type [CLASS_KEYS-1:0]            rd_data_ff
);

   entry_type [CLASS_KEYS-1:0] mem [STATE_COUNT];

   always_ff @(posedge clock) begin
      for (int l = 0; l < CLASS_KEYS; l++) begin
         if (wr.en && wr.mask[l]) begin
            mem[wr_row][l] <= wr.data;
         end
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

endmodule

>>> rtl/dfacc_pick.sv
// Result select: literal entry first, then the first present class whose test holds.
module dfacc_pick import dfacc_pkg::*; (
   input  s1_type                     s1,
   input  entry_type                  lit,
   input  entry_type [CLASS_KEYS-1:0] cls,
   output rsp_type                    rsp
);

   logic [CLASS_KEYS-1:0] hits;

   always_comb begin
      hits = class_hits(s1.ch);
      rsp  = '0;
      if (!s1.step) begin
         rsp.found = s1.ok;
      end else if (s1.ok) begin
         if (lit.valid) begin
            rsp.found      = 1'b1;
            rsp.next_state = lit.state;
         end else begin
            for (int k = CLASS_KEYS - 1; k >= 0; k--) begin
               // lowest lane wins, so walk down
               if (cls[k].valid && hits[k]) begin
                  rsp.found      = 1'b1;
                  rsp.next_state = cls[k].state;
               end
            end
         end
      end
   end

endmodule

>>> rtl/dfacc_check.sv
// Port-level checks for the lexer DFA step block, bound to its top level.
module dfacc_check (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // a newly raised result word must trace back to an accepted request word
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result word without matching request");

   // not-found and write results carry a zero state
   a_zero_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[6] |-> rsp_tdata[5:0] == 6'd0)
      else $error("state field set without a match");

   // clearing pass blocks requests right after reset
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_tready)
      else $error("request taken during clearing pass");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

endmodule

bind dfa_step_with_char_classes dfacc_check u_dfacc_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/sv/dfa_step_with_char_classes_tb.sv
// Self-checking testbench for the lexer DFA transition store and step unit.
`timescale 1ns / 1ps

module dfa_step_with_char_classes_tb import dfacc_pkg::*;;

   localparam int WATCHDOG_LIMIT = 60000;   // covers the clearing pass after reset
   localparam int HOLD_CYCLES    = 400;
   localparam int TAIL_CYCLES    = 12;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              csr_we     = 1'b0;
   logic [SIU_W-1:0]  csr_wdata  = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic              req_tuser  = FUNC_WRITE;
   logic [23:0]       req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;

   // shadow copy of the transition store
   entry_type         lit_entry [STATE_COUNT_DEF*LIT_KEYS];
   entry_type         cls_entry [STATE_COUNT_DEF*CLASS_KEYS];
   logic [SIU_W-1:0]  siu_shadow;
   rsp_type           dfa_results_q [$];

   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;
   bit hold_start   = 1'b0;
   int hold_left    = 0;
   int idle_cycles  = 0;
   int error_count  = 0;
   int n_results    = 0;
   int n_writes     = 0;
   int n_writes_ok  = 0;
   int n_steps      = 0;
   int n_hits       = 0;

   always #10 clock = ~clock;

   dfa_step_with_char_classes #(
      .STATE_COUNT (STATE_COUNT_DEF)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // C-locale character tests, one per class lane
   function automatic bit in_class(int lane, logic [7:0] c);
      bit dig;
      dig = (c >= "0") && (c <= "9");
      case (lane)
         CLS_LETTER:  return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
         CLS_SPACE:   return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
         CLS_DIGIT:   return dig;
         CLS_NZDIGIT: return dig && (c != "0");
         CLS_OCTAL:   return dig && (c != "8") && (c != "9");
         CLS_HEX:     return dig || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
         CLS_DQ_STR:  return (c != "\\") && (c != "\"") && (c != "\n");
         CLS_SQ_STR:  return (c != "\\") && (c != "'") && (c != "\n");
         default:     return c != "\\";
      endcase
   endfunction

   // applies one word to the shadow store and returns the result it must produce
   function automatic rsp_type dfa_apply(logic func, logic [5:0] from, logic present,
                                         logic [8:0] sym, logic [5:0] to);
      rsp_type   r;
      entry_type e;
      r = '0;
      if (func == FUNC_WRITE) begin
         if (from < siu_shadow && to < siu_shadow && sym <= KEY_LAST) begin
            e.valid = 1'b1;
            e.state = to;
            if (sym < LIT_KEYS)
               lit_entry[from*LIT_KEYS + sym] = e;
            else
               cls_entry[from*CLASS_KEYS + (sym - LIT_KEYS)] = e;
            r.found = 1'b1;
         end
      end else if (present && sym < LIT_KEYS) begin
         e = lit_entry[from*LIT_KEYS + sym];
         if (e.valid) begin
            r.found      = 1'b1;
            r.next_state = e.state;
         end else begin
            for (int lane = 0; lane < CLASS_KEYS && !r.found; lane++) begin
               e = cls_entry[from*CLASS_KEYS + lane];
               if (e.valid && in_class(lane, sym[7:0])) begin
                  r.found      = 1'b1;
                  r.next_state = e.state;
               end
            end
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] pick_byte();
      logic [7:0] pool [0:15] = '{"a", "z", "A", "Z", "0", "8", "9", "f",
                                   "F", "g", " ", "\t", "\n", "\\", "\"", "'"};
      if ($urandom_range(99) < 60)
         return pool[$urandom_range(15)];
      return 8'($urandom_range(255));
   endfunction

   task automatic send_word(input logic func, input logic [5:0] from, input logic present,
                            input logic [8:0] sym, input logic [5:0] to);
      rsp_type r;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {2'b00, to, sym, present, from};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = dfa_apply(func, from, present, sym, to);
      dfa_results_q.push_back(r);
      if (func == FUNC_WRITE) begin
         n_writes++;
         n_writes_ok += r.found;
      end else begin
         n_steps++;
         n_hits += r.found;
      end
   endtask

   // sender goes quiet until every outstanding result is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (dfa_results_q.size() != 0);
   endtask

   task automatic set_states_in_use(input logic [SIU_W-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      siu_shadow = value;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_word(output logic func, output logic [5:0] from,
                              output logic present, output logic [8:0] sym,
                              output logic [5:0] to);
      int lim;
      lim     = (siu_shadow > STATE_COUNT_DEF) ? STATE_COUNT_DEF : int'(siu_shadow);
      func    = ($urandom_range(99) < 35) ? FUNC_WRITE : FUNC_STEP;
      from    = ($urandom_range(99) < 75) ? 6'($urandom_range(7)) : 6'($urandom);
      present = ($urandom_range(99) < 94);
      to      = 6'($urandom);
      if (func == FUNC_WRITE) begin
         if (lim > 0 && $urandom_range(99) < 85) begin
            to = 6'($urandom_range(lim - 1));
            if (from >= lim) from = 6'($urandom_range(lim - 1));
         end
         case ($urandom_range(9))
            0:       sym = 9'($urandom_range(265, 511));            // key past last class
            1, 2, 3, 4: sym = 9'(LIT_KEYS + $urandom_range(CLASS_KEYS - 1));
            default: sym = {1'b0, pick_byte()};
         endcase
      end else begin
         sym = ($urandom_range(99) < 95) ? {1'b0, pick_byte()} : 9'($urandom_range(256, 511));
      end
   endtask

   task automatic test_basic_transitions();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      set_states_in_use(7'd64);
      send_word(FUNC_STEP,  6'd0,  1'b1, 9'("a"), 6'd0);        // empty store
      send_word(FUNC_WRITE, 6'd0,  1'b0, 9'("a"), 6'd63);
      send_word(FUNC_WRITE, 6'd63, 1'b1, 9'd255, 6'd0);
      send_word(FUNC_WRITE, 6'd0,  1'b1, 9'(LIT_KEYS + CLS_LETTER), 6'd1);
      send_word(FUNC_WRITE, 6'd0,  1'b0, KEY_LAST, 6'd2);
      send_word(FUNC_WRITE, 6'd0,  1'b1, KEY_LAST + 9'd1, 6'd3);
      send_word(FUNC_WRITE, 6'd0,  1'b1, 9'd511, 6'd4);
      send_word(FUNC_STEP,  6'd0,  1'b1, 9'("a"), 6'd63);       // literal beats class
      send_word(FUNC_STEP,  6'd0,  1'b1, 9'("b"), 6'd0);
      send_word(FUNC_STEP,  6'd0,  1'b1, 9'("\\"), 6'd0);
      send_word(FUNC_STEP,  6'd0,  1'b1, 9'("#"), 6'd0);
      send_word(FUNC_STEP,  6'd63, 1'b1, 9'd255, 6'd0);
      send_word(FUNC_STEP,  6'd0,  1'b0, 9'("a"), 6'd0);
      send_word(FUNC_STEP,  6'd0,  1'b1, 9'd256, 6'd0);
      send_word(FUNC_STEP,  6'd0,  1'b1, 9'd511, 6'd63);
      send_word(FUNC_WRITE, 6'd0,  1'b1, 9'("a"), 6'd7);        // rewrite
      send_word(FUNC_STEP,  6'd0,  1'b1, 9'("a"), 6'd0);
   endtask

   task automatic test_state_limit();
      set_states_in_use(7'd1);
      send_word(FUNC_WRITE, 6'd0,  1'b1, 9'("x"), 6'd0);
      send_word(FUNC_WRITE, 6'd1,  1'b1, 9'("x"), 6'd0);
      send_word(FUNC_WRITE, 6'd0,  1'b1, 9'("x"), 6'd1);
      send_word(FUNC_STEP,  6'd63, 1'b1, 9'd255, 6'd0);         // steps ignore the limit
      set_states_in_use(7'd0);
      send_word(FUNC_WRITE, 6'd0,  1'b1, 9'd0, 6'd0);
   endtask

   task automatic test_random_traffic(input int count, input logic [SIU_W-1:0] siu,
                                      input int tx_pct, input int rx_pct);
      logic       func, present;
      logic [5:0] from, to;
      logic [8:0] sym;
      set_states_in_use(siu);
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) == 0) wait_drained();
         random_word(func, from, present, sym, to);
         send_word(func, from, present, sym, to);
      end
   endtask

   // long output stall while input keeps coming: pipe fills and req must stall
   task automatic test_output_backpressure();
      logic       func, present;
      logic [5:0] from, to;
      logic [8:0] sym;
      set_states_in_use(7'($urandom_range(2, 63)));
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      hold_start   = 1'b1;
      for (int i = 0; i < 100; i++) begin
         random_word(func, from, present, sym, to);
         send_word(func, from, present, sym, to);
      end
   endtask

   // receiver: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  = hold_left - 1;
      end else if (hold_start) begin
         hold_start = 1'b0;
         hold_left  = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_results++;
         if (dfa_results_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result word, expected none, actual 0x%02h",
                     $time, rsp_tdata);
         end else begin
            want = dfa_results_q.pop_front();
            if (rsp_tdata[5:0] !== want.next_state) begin
               error_count++;
               $display("%0t: next_state mismatch, expected %0d, actual %0d",
                        $time, want.next_state, rsp_tdata[5:0]);
            end
            if (rsp_tdata[6] !== want.found) begin
               error_count++;
               $display("%0t: found mismatch, expected %0b, actual %0b",
                        $time, want.found, rsp_tdata[6]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, dfa_results_q.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      foreach (lit_entry[i]) lit_entry[i] = '0;
      foreach (cls_entry[i]) cls_entry[i] = '0;
      siu_shadow = SIU_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_basic_transitions();
      test_state_limit();
      test_random_traffic(250, 7'd64, 0, 0);
      test_random_traffic(250, 7'($urandom_range(2, 63)), 45, 0);
      test_random_traffic(200, 7'd1, 0, 45);
      test_random_traffic(250, 7'd64, 26, 26);
      test_output_backpressure();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d results: %0d writes (%0d taken), %0d steps (%0d matched).",
               n_results, n_writes, n_writes_ok, n_steps, n_hits);
      $display("Limits 0, 1, mid and 64; idle, stall and long output hold-off phases.");
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> dfa_step_with_char_classes.f
rtl/dfacc_pkg.sv
rtl/dfacc_lit_mem.sv
rtl/dfacc_cls_mem.sv
rtl/dfacc_pick.sv
rtl/dfa_step_with_char_classes.sv
rtl/dfacc_check.sv
tb/sv/dfa_step_with_char_classes_tb.sv
